>>> rtl/led_blink_pattern_sequencer_assert.svh
// Assertion macros for the LED blink pattern sequencer.
// Included by the top level; uses no package and no other header.
`ifndef LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbps assertion failed");

// Next-cycle implication, checked outside reset.
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

`endif

>>> rtl/lbps_pkg.sv
// Shared types and constants for the LED blink pattern sequencer.
// No dependencies; imported by lbps_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lbps_pkg;

    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int TICK_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_FOREVER = 3'd0,
        MODE_SLOW    = 3'd1,
        MODE_SINGLE  = 3'd2,
        MODE_DOUBLE  = 3'd3,
        MODE_CONT    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_FLASH   = 2'd1,
        PH_OFF     = 2'd2,
        PH_PAUSE   = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW  = 2'd0,
        CFG_FAST  = 2'd1,
        CFG_PAUSE = 2'd2
    } t_cfg_idx;

    // Command word held in the input register.
    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] mode;
    } t_cmd;

    // Phase lengths from the configuration registers.
    typedef struct packed {
        logic [CFG_W-1:0] slow;
        logic [CFG_W-1:0] fast;
        logic [CFG_W-1:0] pause;
    } t_len_cfg;

    // Result of one command: LED level and phase after it.
    typedef struct packed {
        logic   led;
        t_phase phase;
    } t_seq_out;

endpackage
`default_nettype wire

>>> rtl/led_blink_pattern_sequencer.sv
// LED blink pattern sequencer
//
// Input stream (s_axis): one command word per beat; tuser carries the opcode
// (tick, start with mode, or stop) and tdata the mode.
// Output stream (m_axis): exactly one result word per command, in order, giving
// the LED level and blink phase after that command.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 slow length, 1 fast length, 2 pause length, in ticks); index 3 is dropped.
// Write config only while no command is in flight.
//
// Timing: an accepted word is held in the input register, and its result is
// registered into the output register once the output register is free.
// Throughput: one word per cycle while results are taken; each command is one
// decrement, one compare and a phase update in lbps_seq between the registers.
// Stall: while the output word waits, the input register still takes one more
// word; o_s_axis_tready drops only when both registers are full.
// Reset: LED off, phase stopped, lengths 500/100/1000, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "led_blink_pattern_sequencer_assert.svh"
module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [7:0]           i_s_axis_tdata,   // mode[2:0], zero pad
    input  wire logic [1:0]           i_s_axis_tuser,   // opcode[1:0]
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata,   // led_on[0], phase[2:1], zero pad
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic     r_in_valid;
    t_cmd     r_in_cmd;
    logic     r_out_valid;
    t_seq_out r_out;
    t_len_cfg r_len;
    t_seq_out w_next;
    logic     w_out_free;
    logic     w_adv;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len.slow  <= CFG_W'(500);
            r_len.fast  <= CFG_W'(100);
            r_len.pause <= CFG_W'(1000);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLOW:  r_len.slow  <= i_cfg_data;
                CFG_FAST:  r_len.fast  <= i_cfg_data;
                CFG_PAUSE: r_len.pause <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register: load a word whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd.opcode <= i_s_axis_tuser;
            r_in_cmd.mode   <= i_s_axis_tdata[2:0];
        end
    end

    lbps_seq #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cmd   (r_in_cmd),
        .i_len   (r_len),
        .o_next  (w_next)
    );

    // output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.phase, r_out.led};

    `LBPS_ASSERT_NOW(a_stall_src, i_clk, i_rst_n, !o_s_axis_tready,
        r_in_valid && r_out_valid && !i_m_axis_tready)
    `LBPS_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `LBPS_ASSERT_NOW(a_led_flash, i_clk, i_rst_n, r_out_valid,
        r_out.led == (r_out.phase == PH_FLASH))

endmodule
`default_nettype wire

>>> rtl/lbps_seq.sv
// Blink sequencer state: phase, mode, countdown, LED level.
// Depends on lbps_pkg; one command is applied per i_adv cycle.
`timescale 1ns / 1ps
`default_nettype none
module lbps_seq
    import lbps_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire t_cmd     i_cmd,
    input  wire t_len_cfg i_len,
    output t_seq_out      o_next
);

    logic [TICK_WIDTH-1:0] w_slow;
    logic [TICK_WIDTH-1:0] w_fast;
    logic [TICK_WIDTH-1:0] w_pause;
    logic [TICK_WIDTH-1:0] w_blink;

    t_phase                r_phase, n_phase;
    t_mode                 r_mode, n_mode;
    logic                  r_second, n_second;
    logic [TICK_WIDTH-1:0] r_cnt, n_cnt;
    logic                  r_run, n_run;
    logic                  r_led, n_led;

    // Fit the 16-bit lengths to the counter, saturating when it is narrower.
    generate
        if (TICK_WIDTH >= CFG_W) begin : g_wide
            assign w_slow  = TICK_WIDTH'(i_len.slow);
            assign w_fast  = TICK_WIDTH'(i_len.fast);
            assign w_pause = TICK_WIDTH'(i_len.pause);
        end else begin : g_narrow
            localparam logic [CFG_W-1:0] LIM = CFG_W'((64'd1 << TICK_WIDTH) - 64'd1);
            assign w_slow  = (i_len.slow  > LIM) ? '1 : i_len.slow[TICK_WIDTH-1:0];
            assign w_fast  = (i_len.fast  > LIM) ? '1 : i_len.fast[TICK_WIDTH-1:0];
            assign w_pause = (i_len.pause > LIM) ? '1 : i_len.pause[TICK_WIDTH-1:0];
        end
    endgenerate

    assign w_blink = (r_mode == MODE_SLOW) ? w_slow : w_fast;

    always_comb begin
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_second = r_second;
        n_cnt    = r_cnt;
        n_run    = r_run;
        n_led    = r_led;
        if (i_adv) begin
            unique case (t_opcode'(i_cmd.opcode))
                OP_TICK: begin
                    if (r_phase != PH_STOPPED && r_run) begin
                        if (r_cnt > TICK_WIDTH'(1)) begin
                            n_cnt = r_cnt - TICK_WIDTH'(1);
                        end else begin
                            unique case (r_phase)
                                PH_FLASH: begin
                                    n_phase = PH_OFF;
                                    n_led   = 1'b0;
                                    n_cnt   = w_blink;
                                end
                                PH_OFF: begin
                                    if (r_mode == MODE_SINGLE ||
                                        (r_mode == MODE_DOUBLE && r_second)) begin
                                        n_second = 1'b0;
                                        n_phase  = PH_PAUSE;
                                        n_cnt    = w_pause;
                                    end else begin
                                        // second shot of a double flash, or plain blink
                                        if (r_mode == MODE_DOUBLE) begin
                                            n_second = 1'b1;
                                        end
                                        n_phase = PH_FLASH;
                                        n_led   = 1'b1;
                                        n_cnt   = w_blink;
                                    end
                                end
                                PH_PAUSE: begin
                                    n_phase = PH_FLASH;
                                    n_led   = 1'b1;
                                    n_cnt   = w_blink;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                OP_START: begin
                    // drop starts with an undefined mode
                    if (i_cmd.mode <= MODE_CONT) begin
                        n_mode   = t_mode'(i_cmd.mode);
                        n_second = 1'b0;
                        n_phase  = PH_FLASH;
                        n_led    = 1'b1;
                        if (i_cmd.mode == MODE_FOREVER) begin
                            n_run = 1'b0;
                            n_cnt = '0;
                        end else begin
                            n_run = 1'b1;
                            n_cnt = (i_cmd.mode == MODE_SLOW) ? w_slow : w_fast;
                        end
                    end
                end
                OP_STOP: begin
                    n_run   = 1'b0;
                    n_phase = PH_STOPPED;
                    n_led   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_STOPPED;
            r_mode   <= MODE_FOREVER;
            r_second <= 1'b0;
            r_cnt    <= '0;
            r_run    <= 1'b0;
            r_led    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_mode   <= n_mode;
            r_second <= n_second;
            r_cnt    <= n_cnt;
            r_run    <= n_run;
            r_led    <= n_led;
        end
    end

    assign o_next.led   = n_led;
    assign o_next.phase = n_phase;

endmodule
`default_nettype wire

>>> tb/sv/led_blink_pattern_sequencer_tb.sv
// Self-checking testbench for led_blink_pattern_sequencer: command words in, LED words out.
// Depends on lbps_pkg and the RTL top level; a scoreboard class predicts every result word.
`timescale 1ns / 1ps
module led_blink_pattern_sequencer_tb;
    import lbps_pkg::*;

    localparam logic [1:0]           OP_RSVD      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam int                   HOLD_CYCLES  = 250;
    localparam int                   DRAIN_LIMIT  = 20000;
    localparam int                   SETTLE       = 8;
    localparam int                   PHASE_ITEMS  = 170;

    // Predicts LED level and phase for every accepted command word.
    class blink_scoreboard;
        logic [CFG_W-1:0] slow_len, fast_len, pause_len;
        t_phase           phase_q;
        t_mode            mode_q;
        logic             second_done;
        logic [15:0]      count_q;
        logic             running;
        logic             led_q;
        t_seq_out         expected_words[$];
        int               n_checked;
        int               n_errors;

        function new();
            slow_len    = 16'd500;
            fast_len    = 16'd100;
            pause_len   = 16'd1000;
            phase_q     = PH_STOPPED;
            mode_q      = MODE_FOREVER;
            second_done = 1'b0;
            count_q     = '0;
            running     = 1'b0;
            led_q       = 1'b0;
            n_checked   = 0;
            n_errors    = 0;
        endfunction

        function void set_len(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SLOW:  slow_len  = val;
                CFG_FAST:  fast_len  = val;
                CFG_PAUSE: pause_len = val;
                default: ;
            endcase
        endfunction

        function logic [CFG_W-1:0] blink_len();
            return (mode_q == MODE_SLOW) ? slow_len : fast_len;
        endfunction

        function void load(logic [CFG_W-1:0] len);
            count_q = len;
            running = 1'b1;
        endfunction

        function void go_flash();
            phase_q = PH_FLASH;
            led_q   = 1'b1;
            load(blink_len());
        endfunction

        function void go_pause();
            phase_q = PH_PAUSE;
            load(pause_len);
        endfunction

        function void end_of_phase();
            case (phase_q)
                PH_FLASH: begin
                    phase_q = PH_OFF;
                    led_q   = 1'b0;
                    load(blink_len());
                end
                PH_OFF: begin
                    if (mode_q == MODE_SINGLE) begin
                        go_pause();
                    end else if (mode_q == MODE_DOUBLE) begin
                        // second flash first, pause after it
                        if (!second_done) begin
                            second_done = 1'b1;
                            go_flash();
                        end else begin
                            second_done = 1'b0;
                            go_pause();
                        end
                    end else begin
                        go_flash();
                    end
                end
                PH_PAUSE: go_flash();
                default: ;
            endcase
        endfunction

        function void note_command(logic [1:0] op, logic [2:0] md);
            t_seq_out w;
            case (op)
                OP_TICK: begin
                    if (phase_q != PH_STOPPED && running) begin
                        if (count_q <= 16'd1) end_of_phase();
                        else count_q = count_q - 16'd1;
                    end
                end
                OP_START: begin
                    if (md <= MODE_CONT) begin
                        mode_q      = t_mode'(md);
                        second_done = 1'b0;
                        phase_q     = PH_FLASH;
                        led_q       = 1'b1;
                        if (mode_q == MODE_FOREVER) begin
                            running = 1'b0;
                            count_q = '0;
                        end else begin
                            load(blink_len());
                        end
                    end
                end
                OP_STOP: begin
                    running = 1'b0;
                    phase_q = PH_STOPPED;
                    led_q   = 1'b0;
                end
                default: ;
            endcase
            w.led   = led_q;
            w.phase = phase_q;
            expected_words.push_back(w);
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= 40) $display("mismatch: %s", msg);
        endtask

        task check_word(logic [7:0] data);
            t_seq_out w;
            n_checked++;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %02h", data));
            end else begin
                w = expected_words.pop_front();
                if (data[0] !== w.led)
                    report($sformatf("word %0d led %b, want %b", n_checked, data[0], w.led));
                if (data[2:1] !== w.phase)
                    report($sformatf("word %0d phase %0d, want %0d", n_checked, data[2:1],
                                     w.phase));
            end
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata  = '0;   // mode[2:0], zero pad
    logic [1:0]           i_s_axis_tuser  = '0;   // opcode[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [7:0]           o_m_axis_tdata;         // led_on[0], phase[2:1], zero pad
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [CFG_W-1:0]     i_cfg_data      = '0;

    blink_scoreboard sb = new();

    led_blink_pattern_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Offer one command word and hold it until the block takes it.
    task automatic send_cmd(logic [1:0] op, logic [2:0] md);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {5'b00000, md};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_command(op, md);
    endtask

    task automatic idle_input(int n);
        i_s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_len(idx, val);
    endtask

    task automatic set_lengths(logic [CFG_W-1:0] s, logic [CFG_W-1:0] f, logic [CFG_W-1:0] p);
        write_cfg(CFG_SLOW, s);
        write_cfg(CFG_FAST, f);
        write_cfg(CFG_PAUSE, p);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait for every predicted word, then let the pipeline settle.
    task automatic drain();
        int n;
        n = 0;
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        int       r, gap;
        bit       calm;
        logic [1:0] op;
        logic [2:0] md;
        calm = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) calm = ($urandom_range(0, 2) == 0);
            r  = $urandom_range(0, 99);
            md = 3'($urandom_range(0, 7));
            if (r < 80) begin
                op = OP_TICK;
            end else if (r < 90) begin
                op = OP_START;
                md = 3'($urandom_range(MODE_FOREVER, MODE_CONT));
            end else if (r < 93) begin
                op = OP_START;
                md = 3'($urandom_range(5, 7));
            end else if (r < 97) begin
                op = OP_STOP;
            end else begin
                op = OP_RSVD;
            end
            send_cmd(op, md);
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
                idle_input(gap);
            end
        end
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin : result_sink
        int  stall_left;
        int  cyc;
        bit  calm;
        bit  held;
        bit  rdy;
        stall_left = 0;
        cyc        = 0;
        calm       = 1'b0;
        held       = 1'b0;
        forever begin
            if (!held && sb.n_checked >= 100) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (cyc % 100 == 0) calm = ($urandom_range(0, 2) == 0);
            cyc++;
            if (stall_left > 0) begin
                rdy = 1'b0;
                stall_left--;
            end else begin
                rdy = 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                             : $urandom_range(1, 3);
            end
            i_m_axis_tready <= rdy;
            @(posedge i_clk);
            if (i_rst_n && rdy && o_m_axis_tvalid) sb.check_word(o_m_axis_tdata);
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset lengths: stopped block, ignored commands, on forever, then a slow blink start.
        send_cmd(OP_TICK, MODE_SLOW);
        send_cmd(OP_RSVD, MODE_CONT);
        send_cmd(OP_STOP, MODE_FOREVER);
        send_cmd(OP_START, MODE_FOREVER);
        send_cmd(OP_TICK, MODE_FOREVER);
        send_cmd(OP_START, 3'd7);
        send_cmd(OP_START, 3'd5);
        send_cmd(OP_START, 3'd6);
        send_cmd(OP_START, MODE_SLOW);
        send_cmd(OP_TICK, 3'd7);
        drain();

        // Short lengths so the single, double and continuous modes walk through their phases.
        set_lengths(16'd1, 16'd1, 16'd2);
        write_cfg(CFG_UNUSED, 16'hFFFF);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_cmd(OP_START, MODE_SINGLE);
        repeat (4) send_cmd(OP_TICK, MODE_FOREVER);
        send_cmd(OP_START, MODE_DOUBLE);
        repeat (6) send_cmd(OP_TICK, MODE_FOREVER);
        send_cmd(OP_START, MODE_CONT);
        repeat (2) send_cmd(OP_TICK, MODE_FOREVER);
        send_cmd(OP_START, MODE_SLOW);
        send_cmd(OP_START, MODE_SLOW);
        send_cmd(OP_TICK, MODE_FOREVER);
        send_cmd(OP_STOP, MODE_FOREVER);
        send_cmd(OP_TICK, MODE_FOREVER);
        drain();

        set_lengths(16'd0, 16'd0, 16'd0);
        random_phase(PHASE_ITEMS);
        drain();
        set_lengths(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                    16'($urandom_range(1, 4)));
        random_phase(PHASE_ITEMS);
        drain();
        set_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(PHASE_ITEMS);
        drain();
        set_lengths(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                    16'($urandom_range(0, 7)));
        random_phase(PHASE_ITEMS);
        drain();
        set_lengths(16'd3, 16'hFFFF, 16'd1);
        random_phase(PHASE_ITEMS);
        drain();
        set_lengths(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                    16'($urandom_range(1, 6)));
        random_phase(PHASE_ITEMS);
        drain();

        if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lbps_pkg.sv
rtl/lbps_seq.sv
rtl/led_blink_pattern_sequencer.sv
tb/sv/led_blink_pattern_sequencer_tb.sv
